// File: src/vlm_pkg.sv
// ----------------------------------------------------------------------------
// Voxel label map package
// Grid sizes, codes, word layouts and the attribute match test.
// ----------------------------------------------------------------------------
package vlm_pkg;

    localparam int GRID_X = 256;
    localparam int GRID_Y = 256;
    localparam int GRID_Z = 8;
    localparam int NVOX   = GRID_X * GRID_Y * GRID_Z;
    localparam int ADDR_W = $clog2(NVOX);

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 16;
    localparam int LABEL_W    = 32;
    localparam int ATTR_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // Product of a 17-bit offset and a 17-bit signed reciprocal.
    localparam int PROD_W     = 34;
    // Rounded voxel index before the range check.
    localparam int VIDX_W     = 18;

    // Command queue between the front end and the sequencer.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_XY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Z  = 3'd4;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_OCC   = 2'd1;
    localparam logic [1:0] ST_BLOCK = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               outside;
        logic               nb_ok;
        logic               nmode;
        logic [ADDR_W-1:0]  addr;
        logic [LABEL_W-1:0] label;
        logic [ATTR_W-1:0]  seg_width;
        logic [ATTR_W-1:0]  seg_top;
    } vlm_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [LABEL_W-1:0] label;
        logic [ATTR_W-1:0]  width;
        logic [ATTR_W-1:0]  top;
    } vlm_voxel_t;

    typedef struct packed {
        logic               hit;
        logic [LABEL_W-1:0] found_label;
        logic               outside;
    } vlm_result_t;

    // Width differs by less than either width, twice the top difference by
    // less than either top.
    function automatic logic attr_match(input vlm_voxel_t v,
                                        input logic [ATTR_W-1:0] w,
                                        input logic [ATTR_W-1:0] t);
        logic [ATTR_W-1:0] dw;
        logic [ATTR_W-1:0] dt1;
        logic [ATTR_W:0]   dt;
        dw  = (v.width > w) ? (v.width - w) : (w - v.width);
        dt1 = (v.top > t) ? (v.top - t) : (t - v.top);
        dt  = {dt1, 1'b0};
        return (dw < w) && (dw < v.width) && (dt < {1'b0, t}) && (dt < {1'b0, v.top});
    endfunction

endpackage

// File: src/voxel_label_map_core.sv
// ----------------------------------------------------------------------------
// Voxel label map core
// Lidar voxel grid of segment labels: clear, insert and lookup by point.
// ----------------------------------------------------------------------------
// An item passes the front-end register and the command queue; the sequencer
// checks the store in S_CENTRE for an insert or a lookup (a neighbour lookup
// goes on to S_NB and S_DECIDE) and queues the result word. It takes a new item
// only when idle, as the store has a single read port; a neighbour lookup holds
// the store while it reads the neighbours. Clear and reset sweep one voxel per
// cycle; after reset full stays high for the whole sweep.
// ----------------------------------------------------------------------------
module voxel_label_map_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [vlm_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [vlm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                push,
    output logic                                full,
    input  logic [vlm_pkg::CMD_W-1:0]           cmd,
    input  logic signed [vlm_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [vlm_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [vlm_pkg::COORD_W-1:0]  coord_z,
    input  logic [vlm_pkg::LABEL_W-1:0]         label,
    input  logic [vlm_pkg::ATTR_W-1:0]          seg_width,
    input  logic [vlm_pkg::ATTR_W-1:0]          seg_top,
    input  logic                                neighbor_mode,
    output logic                                empty,
    input  logic                                pop,
    output logic                                hit,
    output logic [vlm_pkg::LABEL_W-1:0]         found_label,
    output logic                                outside
);

    logic                 front_busy, init_busy, in_accept;
    logic                 q_push, q_full, q_pop, q_empty;
    vlm_pkg::vlm_item_t   q_in_item, q_out_item;
    vlm_pkg::vlm_result_t res_word;

    assign full      = front_busy || init_busy;
    assign in_accept = push && !full;

    vlm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_accept     (in_accept),
        .cmd           (cmd),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .label         (label),
        .seg_width     (seg_width),
        .seg_top       (seg_top),
        .neighbor_mode (neighbor_mode),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in_item),
        .busy          (front_busy)
    );

    vlm_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .empty     (q_empty)
    );

    vlm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_out_item),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .res_pop   (pop),
        .res_empty (empty),
        .res_word  (res_word)
    );

    assign hit         = res_word.hit;
    assign found_label = res_word.found_label;
    assign outside     = res_word.outside;

endmodule

// File: src/vlm_front.sv
// ----------------------------------------------------------------------------
// Voxel label map front end
// Holds the grid registers, scales each point and rounds it to a voxel.
// ----------------------------------------------------------------------------
module vlm_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [vlm_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [vlm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                in_accept,
    input  logic [vlm_pkg::CMD_W-1:0]           cmd,
    input  logic signed [vlm_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [vlm_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [vlm_pkg::COORD_W-1:0]  coord_z,
    input  logic [vlm_pkg::LABEL_W-1:0]         label,
    input  logic [vlm_pkg::ATTR_W-1:0]          seg_width,
    input  logic [vlm_pkg::ATTR_W-1:0]          seg_top,
    input  logic                                neighbor_mode,
    input  logic                                q_full,
    output logic                                q_push,
    output vlm_pkg::vlm_item_t                  q_item,
    output logic                                busy
);

    logic signed [15:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [15:0]        inv_xy_reg, inv_z_reg;

    logic                               s1_valid_reg, s1_valid_next;
    logic [vlm_pkg::CMD_W-1:0]          s1_cmd_reg;
    logic signed [vlm_pkg::PROD_W-1:0]  px_reg, py_reg, pz_reg;
    logic signed [vlm_pkg::PROD_W-1:0]  px_next, py_next, pz_next;
    logic [vlm_pkg::LABEL_W-1:0]        s1_label_reg;
    logic [vlm_pkg::ATTR_W-1:0]         s1_width_reg, s1_top_reg;
    logic                               s1_nmode_reg;

    logic signed [16:0] dx, dy, dz;
    logic signed [16:0] inv_xy_s, inv_z_s;
    logic [vlm_pkg::VIDX_W:0] rx, ry, rz;
    logic [vlm_pkg::VIDX_W-1:0] vx, vy, vz;
    logic in_grid;

    // Rounds half away from zero and checks the index against the grid size.
    function automatic logic [vlm_pkg::VIDX_W:0] axis_round(
        input logic signed [vlm_pkg::PROD_W-1:0] p,
        input logic [vlm_pkg::VIDX_W-1:0] n);
        logic signed [vlm_pkg::PROD_W-1:0] s;
        logic [vlm_pkg::VIDX_W-1:0] v;
        logic ok;
        s = p + 34'sd32768;
        if (!p[vlm_pkg::PROD_W-1]) begin
            v  = s[vlm_pkg::PROD_W-1:16];
            ok = (v < n);
        end
        else begin
            v  = '0;
            ok = (p > -34'sd32768);
        end
        return {ok, v};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= -16'sd20480;
            origin_y_reg <= -16'sd20480;
            origin_z_reg <= 16'sd0;
            inv_xy_reg   <= 16'd853;
            inv_z_reg    <= 16'd512;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                vlm_pkg::CFG_ORIGIN_X:    origin_x_reg <= cfg_wdata;
                vlm_pkg::CFG_ORIGIN_Y:    origin_y_reg <= cfg_wdata;
                vlm_pkg::CFG_ORIGIN_Z:    origin_z_reg <= cfg_wdata;
                vlm_pkg::CFG_INV_CELL_XY: inv_xy_reg   <= cfg_wdata;
                vlm_pkg::CFG_INV_CELL_Z:  inv_z_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        dx = {coord_x[15], coord_x} - {origin_x_reg[15], origin_x_reg};
        dy = {coord_y[15], coord_y} - {origin_y_reg[15], origin_y_reg};
        dz = {coord_z[15], coord_z} - {origin_z_reg[15], origin_z_reg};
        inv_xy_s = $signed({1'b0, inv_xy_reg});
        inv_z_s  = $signed({1'b0, inv_z_reg});
        px_next = dx * inv_xy_s;
        py_next = dy * inv_xy_s;
        pz_next = dz * inv_z_s;
    end

    assign busy   = s1_valid_reg && q_full;
    assign q_push = s1_valid_reg && !q_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (q_push)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg   <= cmd;
            px_reg       <= px_next;
            py_reg       <= py_next;
            pz_reg       <= pz_next;
            s1_label_reg <= label;
            s1_width_reg <= seg_width;
            s1_top_reg   <= seg_top;
            s1_nmode_reg <= neighbor_mode;
        end
    end

    always_comb
    begin
        rx = axis_round(px_reg, vlm_pkg::VIDX_W'(vlm_pkg::GRID_X));
        ry = axis_round(py_reg, vlm_pkg::VIDX_W'(vlm_pkg::GRID_Y));
        rz = axis_round(pz_reg, vlm_pkg::VIDX_W'(vlm_pkg::GRID_Z));
        vx = rx[vlm_pkg::VIDX_W-1:0];
        vy = ry[vlm_pkg::VIDX_W-1:0];
        vz = rz[vlm_pkg::VIDX_W-1:0];
        in_grid = rx[vlm_pkg::VIDX_W] && ry[vlm_pkg::VIDX_W] && rz[vlm_pkg::VIDX_W];

        q_item.cmd     = s1_cmd_reg;
        q_item.outside = !in_grid && ((s1_cmd_reg == vlm_pkg::CMD_INSERT) ||
                                      (s1_cmd_reg == vlm_pkg::CMD_LOOKUP));
        q_item.nb_ok   = (vx > '0) && (vx < vlm_pkg::VIDX_W'(vlm_pkg::GRID_X - 1)) &&
                         (vy > '0) && (vy < vlm_pkg::VIDX_W'(vlm_pkg::GRID_Y - 1));
        q_item.nmode   = s1_nmode_reg;
        q_item.addr    = vlm_pkg::ADDR_W'((32'(vz) * vlm_pkg::GRID_Y + 32'(vy))
                                          * vlm_pkg::GRID_X + 32'(vx));
        q_item.label     = s1_label_reg;
        q_item.seg_width = s1_width_reg;
        q_item.seg_top   = s1_top_reg;
    end

endmodule

// File: src/vlm_cmd_queue.sv
// ----------------------------------------------------------------------------
// Voxel label map command queue
// Four-word queue between the front end and the map sequencer.
// ----------------------------------------------------------------------------
module vlm_cmd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vlm_pkg::vlm_item_t push_item,
    output logic               full,
    input  logic               pop,
    output vlm_pkg::vlm_item_t pop_item,
    output logic               empty
);

    vlm_pkg::vlm_item_t                 slot_reg [vlm_pkg::CMDQ_DEPTH];
    logic [vlm_pkg::CMDQ_PTR_W-1:0]     wptr_reg, rptr_reg;
    logic [vlm_pkg::CMDQ_PTR_W:0]       count_reg, count_next;

    assign full     = (count_reg == (vlm_pkg::CMDQ_PTR_W+1)'(vlm_pkg::CMDQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (vlm_pkg::CMDQ_PTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (vlm_pkg::CMDQ_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + vlm_pkg::CMDQ_PTR_W'(1);
            if (pop)
                rptr_reg <= rptr_reg + vlm_pkg::CMDQ_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_item;
    end

endmodule

// File: src/vlm_back.sv
// ----------------------------------------------------------------------------
// Voxel label map sequencer
// Owns the voxel store, carries out clear, insert and lookup, queues results.
// ----------------------------------------------------------------------------
module vlm_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  vlm_pkg::vlm_item_t           q_item,
    output logic                         q_pop,
    output logic                         init_busy,
    input  logic                         res_pop,
    output logic                         res_empty,
    output vlm_pkg::vlm_result_t         res_word
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_CENTRE,
        S_NB,
        S_DECIDE
    } state_t;

    state_t                         state_reg, state_next;
    logic [vlm_pkg::ADDR_W-1:0]     cnt_reg, cnt_next;
    logic                           map_valid_reg, map_valid_next;
    vlm_pkg::vlm_item_t             cur_reg, cur_next;
    logic [1:0]                     nb_idx_reg, nb_idx_next;
    logic                           any_reg, any_next;
    logic                           bad_reg, bad_next;
    vlm_pkg::vlm_voxel_t            cand_reg, cand_next;
    logic [vlm_pkg::ADDR_W-1:0]     cand_addr_reg, cand_addr_next;

    vlm_pkg::vlm_voxel_t            mem [vlm_pkg::NVOX];
    vlm_pkg::vlm_voxel_t            mem_q_reg;
    logic                           rd_en, wr_en;
    logic [vlm_pkg::ADDR_W-1:0]     rd_addr, wr_addr;
    vlm_pkg::vlm_voxel_t            wr_data;

    vlm_pkg::vlm_result_t           res_slot_reg [2];
    logic                           res_wptr_reg, res_rptr_reg;
    logic [1:0]                     res_count_reg;
    logic                           res_full;
    logic                           res_push;
    vlm_pkg::vlm_result_t           res_data;
    logic                           bad_now;

    function automatic logic [vlm_pkg::ADDR_W-1:0] nb_addr(
        input logic [vlm_pkg::ADDR_W-1:0] base, input logic [1:0] n);
        logic [vlm_pkg::ADDR_W-1:0] r;
        case (n)
            2'd0:    r = base - vlm_pkg::ADDR_W'(vlm_pkg::GRID_X);
            2'd1:    r = base - vlm_pkg::ADDR_W'(1);
            2'd2:    r = base + vlm_pkg::ADDR_W'(1);
            default: r = base + vlm_pkg::ADDR_W'(vlm_pkg::GRID_X);
        endcase
        return r;
    endfunction

    assign init_busy = (state_reg == S_INIT);
    assign res_full  = (res_count_reg == 2'd2);
    assign res_empty = (res_count_reg == 2'd0);
    assign res_word  = res_slot_reg[res_rptr_reg];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        map_valid_next = map_valid_reg;
        cur_next       = cur_reg;
        nb_idx_next    = nb_idx_reg;
        any_next       = any_reg;
        bad_next       = bad_reg;
        cand_next      = cand_reg;
        cand_addr_next = cand_addr_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cur_reg.addr;
        wr_en          = 1'b0;
        wr_addr        = cur_reg.addr;
        wr_data        = mem_q_reg;
        res_push       = 1'b0;
        res_data       = '0;
        bad_now        = bad_reg;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = '0;
                cnt_next = cnt_reg + vlm_pkg::ADDR_W'(1);
                if (cnt_reg == vlm_pkg::ADDR_W'(vlm_pkg::NVOX - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (!q_empty && !res_full)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    if (q_item.cmd == vlm_pkg::CMD_CLEAR)
                    begin
                        res_push       = 1'b1;
                        map_valid_next = 1'b1;
                        cnt_next       = '0;
                        state_next     = S_CLEAR;
                    end
                    else if (q_item.outside)
                    begin
                        res_push         = 1'b1;
                        res_data.outside = 1'b1;
                    end
                    else if ((q_item.cmd == vlm_pkg::CMD_INSERT) ||
                             ((q_item.cmd == vlm_pkg::CMD_LOOKUP) && map_valid_reg))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = q_item.addr;
                        state_next = S_CENTRE;
                    end
                    else
                        res_push = 1'b1;
                end
            end

            S_CENTRE:
            begin
                state_next = S_IDLE;
                if (cur_reg.cmd == vlm_pkg::CMD_INSERT)
                begin
                    res_push = 1'b1;
                    if (mem_q_reg.status == vlm_pkg::ST_EMPTY)
                    begin
                        wr_en = 1'b1;
                        wr_data.status = vlm_pkg::ST_OCC;
                        wr_data.label  = cur_reg.label;
                        wr_data.width  = cur_reg.seg_width;
                        wr_data.top    = cur_reg.seg_top;
                    end
                    else if ((mem_q_reg.status == vlm_pkg::ST_OCC) &&
                             (mem_q_reg.label != cur_reg.label))
                    begin
                        wr_en = 1'b1;
                        wr_data.status = vlm_pkg::ST_BLOCK;
                    end
                end
                else if (mem_q_reg.status == vlm_pkg::ST_OCC)
                begin
                    res_push = 1'b1;
                    if (vlm_pkg::attr_match(mem_q_reg, cur_reg.seg_width, cur_reg.seg_top)
                        && (mem_q_reg.label != '0))
                    begin
                        wr_en = 1'b1;
                        wr_data.status = vlm_pkg::ST_BLOCK;
                        res_data.hit = 1'b1;
                        res_data.found_label = mem_q_reg.label;
                    end
                end
                else if ((mem_q_reg.status == vlm_pkg::ST_EMPTY) && cur_reg.nmode &&
                         cur_reg.nb_ok)
                begin
                    nb_idx_next = 2'd0;
                    any_next    = 1'b0;
                    bad_next    = 1'b0;
                    rd_en       = 1'b1;
                    rd_addr     = nb_addr(cur_reg.addr, 2'd0);
                    state_next  = S_NB;
                end
                else
                    res_push = 1'b1;
            end

            S_NB:
            begin
                if (mem_q_reg.status == vlm_pkg::ST_OCC)
                begin
                    if (!any_reg)
                    begin
                        any_next       = 1'b1;
                        cand_next      = mem_q_reg;
                        cand_addr_next = nb_addr(cur_reg.addr, nb_idx_reg);
                    end
                    else if (mem_q_reg.label != cand_reg.label)
                        bad_now = 1'b1;
                end
                bad_next = bad_now;
                if ((nb_idx_reg == 2'd3) || bad_now)
                    state_next = S_DECIDE;
                else
                begin
                    nb_idx_next = nb_idx_reg + 2'd1;
                    rd_en       = 1'b1;
                    rd_addr     = nb_addr(cur_reg.addr, nb_idx_reg + 2'd1);
                end
            end

            S_DECIDE:
            begin
                res_push   = 1'b1;
                state_next = S_IDLE;
                if (any_reg && !bad_reg && (cand_reg.label != '0) &&
                    vlm_pkg::attr_match(cand_reg, cur_reg.seg_width, cur_reg.seg_top))
                begin
                    wr_en   = 1'b1;
                    wr_addr = cand_addr_reg;
                    wr_data = cand_reg;
                    wr_data.status = vlm_pkg::ST_BLOCK;
                    res_data.hit = 1'b1;
                    res_data.found_label = cand_reg.label;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            map_valid_reg <= 1'b0;
            nb_idx_reg    <= '0;
            any_reg       <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            map_valid_reg <= map_valid_next;
            nb_idx_reg    <= nb_idx_next;
            any_reg       <= any_next;
            bad_reg       <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        cand_reg      <= cand_next;
        cand_addr_reg <= cand_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    // Result queue: one word per item, two deep so that a single waiting word
    // does not hold up the next item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wptr_reg  <= 1'b0;
            res_rptr_reg  <= 1'b0;
            res_count_reg <= 2'd0;
        end
        else
        begin
            if (res_push)
                res_wptr_reg <= !res_wptr_reg;
            if (res_pop && !res_empty)
                res_rptr_reg <= !res_rptr_reg;
            if (res_push && !(res_pop && !res_empty))
                res_count_reg <= res_count_reg + 2'd1;
            else if (!res_push && res_pop && !res_empty)
                res_count_reg <= res_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_slot_reg[res_wptr_reg] <= res_data;
    end

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result word written into a full queue");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("command taken while an item is in progress");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(map_valid_reg))
        else $error("map valid flag dropped");

    a_no_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("voxel store written while idle");

endmodule
